// ===== rtl/core/tsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsm_pkg
// Shared constants, codes and types for the three-stack shared memory block.
// ---------------------------------------------------------------------------
package tsm_pkg;

  // Geometry of the shared store
  localparam int SEGMENT_DEPTH = 32;
  localparam int NUM_STACKS    = 3;
  localparam int STORE_WORDS   = NUM_STACKS * SEGMENT_DEPTH;
  localparam int ADDR_W        = $clog2(STORE_WORDS);
  localparam int FILL_W        = $clog2(SEGMENT_DEPTH + 1);

  // Port field widths
  localparam int CMD_W   = 2;
  localparam int SN_W    = 2;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;
  localparam int EXT_W   = FILL_W + COUNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_SIZE = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic exec;      // run the memory access and count update
    logic load_out;  // move the finished result into the output register
  } tsm_ctl_t;

  // Low bits of a fill count as reported on the port
  function automatic logic [COUNT_W-1:0] tsm_fill_out(input logic [FILL_W-1:0] fill);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(fill);
    return ext[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tsm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsm_ctrl
// Sequencer: accept a word, run one store access, hand the result to the
// output register and track its valid flag.
// ---------------------------------------------------------------------------
module tsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tsm_pkg::tsm_ctl_t      ctl
);
  import tsm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Decode commands for the datapath
  always_comb begin
    state_next   = state;
    ctl.capture  = 1'b0;
    ctl.exec     = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsm_datapath
// Input word register, per-stack fill counters, the shared segment store
// with a registered read port, and the output register.
// ---------------------------------------------------------------------------
module tsm_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tsm_pkg::tsm_ctl_t                   ctl,
  input  wire logic [tsm_pkg::CMD_W-1:0]           command,
  input  wire logic [tsm_pkg::SN_W-1:0]            stack_number,
  input  wire logic signed [tsm_pkg::DATA_W-1:0]   push_value,
  output logic signed [tsm_pkg::DATA_W-1:0]        read_value,
  output logic [tsm_pkg::STAT_W-1:0]               status,
  output logic [tsm_pkg::COUNT_W-1:0]              fill_count
);
  import tsm_pkg::*;

  // Captured word
  cmd_t                cmd_q;
  logic [SN_W-1:0]     sn_q;
  logic [DATA_W-1:0]   val_q;

  // Stack state and store
  logic [FILL_W-1:0]   fill_q [NUM_STACKS];
  logic [DATA_W-1:0]   mem [STORE_WORDS];
  logic [DATA_W-1:0]   mem_rd;

  // Result waiting for the output register
  status_t             pend_status;
  logic [FILL_W-1:0]   pend_fill;
  logic                pend_mem;

  // Decode results
  logic                sn_ok;
  logic [FILL_W-1:0]   fill_sel;
  logic                empty;
  logic                full;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                do_wr;
  logic                do_rd;
  logic                fill_upd;
  logic [FILL_W-1:0]   fill_new;
  status_t             res_status;
  logic [FILL_W-1:0]   res_fill;
  logic                res_mem;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd_t'(command);
      sn_q  <= stack_number;
      val_q <= push_value;
    end
  end

  // Select the addressed stack and form store addresses
  always_comb begin
    sn_ok    = (sn_q < SN_W'(NUM_STACKS));
    fill_sel = sn_ok ? fill_q[sn_q] : '0;
    empty    = (fill_sel == '0);
    full     = (fill_sel == FILL_W'(SEGMENT_DEPTH));
    base     = ADDR_W'(sn_q * SEGMENT_DEPTH);
    wr_addr  = base + ADDR_W'(fill_sel);
    rd_addr  = wr_addr - ADDR_W'(1);
  end

  // Decode the command against the stack's fill count
  always_comb begin
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    fill_upd   = 1'b0;
    fill_new   = fill_sel;
    res_status = ST_OK;
    res_fill   = '0;
    res_mem    = 1'b0;
    if (sn_ok) begin
      unique case (cmd_q)
        CMD_PUSH: begin
          if (full) begin
            res_status = ST_FULL;
            res_fill   = fill_sel;
          end else begin
            do_wr    = 1'b1;
            fill_upd = 1'b1;
            fill_new = fill_sel + FILL_W'(1);
            res_fill = fill_new;
          end
        end
        CMD_POP: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            do_rd    = 1'b1;
            fill_upd = 1'b1;
            fill_new = fill_sel - FILL_W'(1);
            res_fill = fill_new;
            res_mem  = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            do_rd    = 1'b1;
            res_fill = fill_sel;
            res_mem  = 1'b1;
          end
        end
        CMD_SIZE: begin
          res_fill = fill_sel;
        end
        default: res_fill = '0;
      endcase
    end
  end

  // Update fill counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_q <= '{default: '0};
    end else if (ctl.exec && fill_upd) begin
      fill_q[sn_q] <= fill_new;
    end
  end

  // Access the segment store
  always_ff @(posedge clk) begin
    if (ctl.exec && do_wr) begin
      mem[wr_addr] <= val_q;
    end
    if (ctl.exec && do_rd) begin
      mem_rd <= mem[rd_addr];
    end
  end

  // Hold the pending result
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      pend_status <= res_status;
      pend_fill   <= res_fill;
      pend_mem    <= res_mem;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      read_value <= pend_mem ? $signed(mem_rd) : '0;
      status     <= pend_status;
      fill_count <= tsm_fill_out(pend_fill);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/three_stacks_shared_memory.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// three_stacks_shared_memory
// Three LIFO stacks in fixed segments of one shared store. Each word carries
// push, pop, peek or size for one stack and returns one result word.
//
//   Channel  Handshake            Fields
//   in       in_valid / in_stall  command, stack_number, push_value
//   out      out_valid / out_stall read_value, status, fill_count
//
// An accepted word is captured, then takes one store access with the count
// update, then is loaded into the output register. A new word is taken
// only once the previous result has been loaded; in_stall stays high
// until then. A held result in the output register blocks the final
// load and so also the next capture. Reset clears the fill counts and the
// output valid; the store contents are not cleared.
// ---------------------------------------------------------------------------
module three_stacks_shared_memory (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [tsm_pkg::CMD_W-1:0]           command,
  input  wire logic [tsm_pkg::SN_W-1:0]            stack_number,
  input  wire logic signed [tsm_pkg::DATA_W-1:0]   push_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [tsm_pkg::DATA_W-1:0]        read_value,
  output logic [tsm_pkg::STAT_W-1:0]               status,
  output logic [tsm_pkg::COUNT_W-1:0]              fill_count
);
  import tsm_pkg::*;

  tsm_ctl_t ctl;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  tsm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .command      (command),
    .stack_number (stack_number),
    .push_value   (push_value),
    .read_value   (read_value),
    .status       (status),
    .fill_count   (fill_count)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tsm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsm_checker
// Port-level checks on the result channel of the three-stack block.
// ---------------------------------------------------------------------------
module tsm_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [tsm_pkg::DATA_W-1:0]   read_value,
  input wire logic [tsm_pkg::STAT_W-1:0]          status,
  input wire logic [tsm_pkg::COUNT_W-1:0]         fill_count
);
  import tsm_pkg::*;

  // Drop any result word out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) &&
                               $stable(status) && $stable(fill_count))
    else $error("stalled result word changed");

  // Empty reads return zero with a zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> read_value == '0 && fill_count == '0)
    else $error("empty result carries data or count");

  // A rejected push reports a full segment and no data
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |->
      read_value == '0 && fill_count == tsm_fill_out(FILL_W'(SEGMENT_DEPTH)))
    else $error("full result with wrong count or data");

  // Status stays within its defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_EMPTY || status == ST_FULL)
    else $error("undefined status code");

endmodule

bind three_stacks_shared_memory tsm_checker u_tsm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_value (read_value),
  .status     (status),
  .fill_count (fill_count)
);
`default_nettype wire
